@@ rtl/core/damped_node_acceleration_defines.svh @@
// Assertion macros for the damped node acceleration block
`ifndef DAMPED_NODE_ACCELERATION_DEFINES_SVH
`define DAMPED_NODE_ACCELERATION_DEFINES_SVH

// Antecedent implies consequent in the same cycle, off during reset.
`define DNA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dna assertion failed");

// Antecedent implies consequent in the next cycle, checked during reset too.
`define DNA_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dna assertion failed");

`endif

@@ rtl/core/dna_pkg.sv @@
// Types and constants shared by the damped node acceleration block
`timescale 1ns / 1ps
package dna_pkg;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LOCAL = 2'd1,
    MODE_COMB  = 2'd2,
    MODE_RSVD  = 2'd3
  } damp_mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FACTOR = 2'd1,
    REG_FIRST  = 2'd2,
    REG_TINY   = 2'd3
  } reg_index_t;

  localparam int DIV_BITS = 33;
  localparam int PROD_W   = 51;
  // front stages + one stage per quotient bit + output register
  localparam int LATENCY  = 3 + DIV_BITS + 1;

  typedef struct packed {
    damp_mode_t  mode;
    logic [15:0] alpha;
    logic        first_step;
    logic [30:0] tiny;
  } cfg_t;

  typedef struct packed {
    logic        fixed;
    logic        presc;
    logic [31:0] pacc;
    logic [31:0] ext_out;
  } side_t;

  typedef struct packed {
    logic                valid;
    logic                neg;
    logic                ovf;
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] low;
    logic [DIV_BITS-1:0] quot;
    logic [31:0]         mass;
    side_t               side;
  } div_t;

endpackage

@@ rtl/core/damped_node_acceleration.sv @@
// Top level of the damped node acceleration pipeline
`timescale 1ns / 1ps
// Usage:
//   An item (one axis of one node) is taken at a rising edge with start high
//   and busy low. busy is low at all times except during reset and the first
//   cycle after it, so a new item may be given on every cycle.
//   Each item yields one result: accel and ext_force_out, shown for exactly
//   one cycle with done high.
//   Throughput is one item per cycle. Behind three stages that form the net
//   force and damping scale, the product and the divider setup come one
//   divider stage per quotient bit (33 stages), then the output register.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must do so only while no item is in flight, as the block does not enforce
//   it. They are sampled as an item enters.
//   Reset (rst, synchronous) empties the pipeline and restores the register
//   defaults: undamped, alpha 0, first step set, tiny force limit 0.
//   The receiver has no stall: results must be taken as they appear.
module damped_node_acceleration (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] ext_force,
  input  logic [31:0] gravity_force,
  input  logic [31:0] internal_force,
  input  logic [31:0] velocity,
  input  logic [31:0] node_mass,
  input  logic        axis_fixed,
  input  logic        axis_prescribed,
  input  logic [31:0] prescribed_acc,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output logic        done,
  output logic [31:0] accel,
  output logic [31:0] ext_force_out
);
  import dna_pkg::*;

  cfg_t  cfg;
  div_t  stage [DIV_BITS+1];
  div_t  last;
  logic [31:0] acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_NONE;
      cfg.alpha      <= '0;
      cfg.first_step <= 1'b1;
      cfg.tiny       <= '0;
      busy           <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_MODE:   cfg.mode       <= damp_mode_t'(cfg_data[1:0]);
          REG_FACTOR: cfg.alpha      <= cfg_data[15:0];
          REG_FIRST:  cfg.first_step <= cfg_data[0];
          REG_TINY:   cfg.tiny       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  dna_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (start && !busy),
    .cfg             (cfg),
    .ext_force       (ext_force),
    .gravity_force   (gravity_force),
    .internal_force  (internal_force),
    .velocity        (velocity),
    .node_mass       (node_mass),
    .axis_fixed      (axis_fixed),
    .axis_prescribed (axis_prescribed),
    .prescribed_acc  (prescribed_acc),
    .out             (stage[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    dna_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign last = stage[DIV_BITS];

  // saturate the signed quotient, then apply the fixed and prescribed overrides
  always_comb begin
    if (last.side.presc) acc_next = last.side.pacc;
    else if (last.side.fixed) acc_next = '0;
    else if (last.neg) begin
      if (last.ovf || last.quot > {2'b01, 31'd0}) acc_next = 32'h8000_0000;
      else acc_next = 32'(-last.quot);
    end else begin
      if (last.ovf || last.quot[32:31] != 2'b00) acc_next = 32'h7fff_ffff;
      else acc_next = last.quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    accel         <= acc_next;
    ext_force_out <= last.side.ext_out;
  end

endmodule

@@ rtl/core/dna_scale.sv @@
// Net force, damping scale, multiply and divider setup (three stages)
`timescale 1ns / 1ps
module dna_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dna_pkg::cfg_t cfg,
  input  logic [31:0]   ext_force,
  input  logic [31:0]   gravity_force,
  input  logic [31:0]   internal_force,
  input  logic [31:0]   velocity,
  input  logic [31:0]   node_mass,
  input  logic          axis_fixed,
  input  logic          axis_prescribed,
  input  logic [31:0]   prescribed_acc,
  output dna_pkg::div_t out
);
  import dna_pkg::*;

  logic [33:0] t;
  logic [32:0] tmag;
  logic [32:0] react;
  logic        t_neg, t_zero, v_neg, v_zero, e_neg, e_zero;
  logic signed [2:0] k;
  logic signed [18:0] f;
  logic signed [18:0] kal;
  logic [18:0] fabs;
  side_t       side_a;

  always_comb begin
    t = {{2{ext_force[31]}}, ext_force} + {{2{gravity_force[31]}}, gravity_force}
      - {{2{internal_force[31]}}, internal_force};
    t_neg  = t[33];
    t_zero = (t == '0);
    tmag   = t_neg ? 33'(-t) : t[32:0];
    v_neg  = velocity[31];
    v_zero = (velocity == '0);
    e_neg  = ext_force[31];
    e_zero = (ext_force == '0);
    // local damping folds sign(v) * |t| into t times a sign factor
    unique case (cfg.mode)
      MODE_LOCAL: begin
        if (cfg.first_step) k = t_zero ? 3'sd0 : 3'sd1;
        else if (tmag < {2'b00, cfg.tiny}) k = 3'sd0;
        else if (v_zero || t_zero) k = 3'sd0;
        else k = (v_neg ^ t_neg) ? -3'sd1 : 3'sd1;
      end
      MODE_COMB: begin
        k = (e_zero ? 3'sd0 : (e_neg ? -3'sd1 : 3'sd1))
          - (v_zero ? 3'sd0 : (v_neg ? -3'sd1 : 3'sd1));
      end
      default: k = 3'sd0;
    endcase
    unique case (k)
      3'sd2:   kal = $signed({2'b00, cfg.alpha, 1'b0});
      3'sd1:   kal = $signed({3'b000, cfg.alpha});
      -3'sd1:  kal = -$signed({3'b000, cfg.alpha});
      -3'sd2:  kal = -$signed({2'b00, cfg.alpha, 1'b0});
      default: kal = 19'sd0;
    endcase
    f    = 19'sd65536 + kal;
    fabs = f[18] ? 19'(-f) : f;
    react = {internal_force[31], internal_force} - {gravity_force[31], gravity_force};
    side_a.fixed = axis_fixed;
    side_a.presc = axis_prescribed;
    side_a.pacc  = prescribed_acc;
    if (!axis_fixed) side_a.ext_out = ext_force;
    else if (react[32] != react[31]) side_a.ext_out = react[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else side_a.ext_out = react[31:0];
  end

  // stage A
  logic        a_valid, a_neg;
  logic [32:0] a_tmag;
  logic [17:0] a_fmag;
  logic [31:0] a_mass;
  side_t       a_side;
  // stage B
  logic        b_valid, b_neg;
  logic [PROD_W-1:0] b_prod;
  logic [31:0] b_mass;
  side_t       b_side;
  logic [17:0] b_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out.valid <= b_valid;
    end
    a_neg  <= t_neg ^ f[18];
    a_tmag <= tmag;
    a_fmag <= fabs[17:0];
    a_mass <= node_mass;
    a_side <= side_a;

    b_neg  <= a_neg;
    b_prod <= a_tmag * a_fmag;
    b_mass <= a_mass;
    b_side <= a_side;

    // quotient above 33 bits or zero mass with a nonzero numerator saturates
    out.neg  <= b_neg;
    out.ovf  <= ({14'b0, b_hi} >= b_mass) && (b_prod != '0);
    out.rem  <= ({14'b0, b_hi} >= b_mass) ? 32'd0 : {14'b0, b_hi};
    out.low  <= b_prod[DIV_BITS-1:0];
    out.quot <= '0;
    out.mass <= b_mass;
    out.side <= b_side;
  end

  assign b_hi = b_prod[PROD_W-1:DIV_BITS];

endmodule

@@ rtl/core/dna_div_stage.sv @@
// One quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps
module dna_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  dna_pkg::div_t din,
  output dna_pkg::div_t dout
);
  import dna_pkg::*;

  logic [32:0] trial;
  logic        ge;

  assign trial = {din.rem, din.low[DIV_BITS-1]};
  // zero mass yields no quotient bits; a nonzero numerator is already flagged
  assign ge    = (din.mass != '0) && (trial >= {1'b0, din.mass});

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.neg  <= din.neg;
    dout.ovf  <= din.ovf;
    dout.rem  <= ge ? 32'(trial - {1'b0, din.mass}) : trial[31:0];
    dout.low  <= {din.low[DIV_BITS-2:0], 1'b0};
    dout.quot <= {din.quot[DIV_BITS-2:0], ge};
    dout.mass <= din.mass;
    dout.side <= din.side;
  end

endmodule

@@ rtl/core/dna_checker.sv @@
// Port-level checks for the damped node acceleration block
`timescale 1ns / 1ps
`include "damped_node_acceleration_defines.svh"
module dna_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        axis_fixed,
  input logic        axis_prescribed,
  input logic [31:0] prescribed_acc,
  input logic        done,
  input logic [31:0] accel
);
  import dna_pkg::*;

  `DNA_ASSERT_NXT(a_busy_after_rst, clk, rst, busy)
  `DNA_ASSERT_IMP(a_done_has_item, clk, rst, done, $past(start && !busy, LATENCY))
  `DNA_ASSERT_IMP(a_item_gives_done, clk, rst, start && !busy, ##LATENCY done)
  `DNA_ASSERT_IMP(a_fixed_zero, clk, rst, start && !busy && axis_fixed && !axis_prescribed, ##LATENCY accel == 32'd0)
  `DNA_ASSERT_IMP(a_presc_acc, clk, rst, done && $past(start && !busy && axis_prescribed, LATENCY), accel == $past(prescribed_acc, LATENCY))

endmodule

bind damped_node_acceleration dna_checker u_dna_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .axis_fixed      (axis_fixed),
  .axis_prescribed (axis_prescribed),
  .prescribed_acc  (prescribed_acc),
  .done            (done),
  .accel           (accel)
);
